@@ design/positional_array_list_assert.svh @@
// assertion macros for the positional array list checker
// expects clk and arst_n in the scope of each use
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// condition holds at every clock out of reset
`define PAL_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PAL_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define PAL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/pal_pkg.sv @@
// shared types and constants for the positional array list
// no dependencies
package pal_pkg;

	localparam int CAPACITY = 128;
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W = 8;
	localparam int DATA_W = 32;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_RETRIEVE = 2'd2;
	localparam logic [1:0] MODE_LOCATE = 2'd3;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_BADPOS = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [CNT_W-1:0] position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0] found_position;
		logic [1:0] status;
		logic [CNT_W-1:0] length;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic wr;
		logic fill;
		logic emit;
	} pal_cmd_t;

	typedef struct packed {
		logic ok;
		logic more;
		logic fill;
	} pal_stat_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DECIDE = 6'b000010,
		ST_READ = 6'b000100,
		ST_WRITE = 6'b001000,
		ST_FILL = 6'b010000,
		ST_RESULT = 6'b100000
	} pal_state_t;

endpackage

@@ design/pal_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module pal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/pal_ctrl.sv @@
// sequencer for the positional array list: handshakes and step order
// depends on pal_pkg
module pal_ctrl import pal_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input pal_stat_t stat,
	output pal_cmd_t cmd
);

	pal_state_t state_q, state_d;
	logic out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (stat.ok && stat.more) begin
					state_d = ST_READ;
				end else if (stat.ok && stat.fill) begin
					state_d = ST_FILL;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_READ: begin
				cmd.rd = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.wr = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ design/pal_datapath.sv @@
// request registers, entry memory, shift and search index, result register
// depends on pal_pkg and pal_ram
module pal_datapath import pal_pkg::*; (
	input logic clk,
	input logic arst_n,
	input req_t in_data,
	input pal_cmd_t cmd,
	output pal_stat_t stat,
	output rsp_t out_data
);

	logic [1:0] mode_q;
	logic [CNT_W-1:0] pos_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0] code_q;
	logic hit_q;
	logic got_q;
	logic [DATA_W-1:0] rd_q;
	rsp_t out_q;

	logic [1:0] code_ld;
	logic [CNT_W-1:0] idx_ld;
	logic [CNT_W-1:0] cnt_p1;
	logic [CNT_W-1:0] count_nx;
	logic ok;

	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	assign cnt_p1 = count_q + CNT_W'(1);
	assign ok = (code_q == STAT_OK);

	always_comb begin
		code_ld = STAT_OK;
		idx_ld = '0;
		case (in_data.mode)
			MODE_INSERT: begin
				idx_ld = count_q;
				if (count_q >= CNT_W'(CAPACITY)) begin
					code_ld = STAT_FULL;
				end else if (in_data.position == '0 || in_data.position > cnt_p1) begin
					code_ld = STAT_BADPOS;
				end
			end
			MODE_DELETE, MODE_RETRIEVE: begin
				idx_ld = in_data.position;
				if (in_data.position == '0 || in_data.position > cnt_p1) begin
					code_ld = STAT_BADPOS;
				end else if (count_q == '0) begin
					code_ld = STAT_EMPTY;
				end else if (in_data.position > count_q) begin
					code_ld = STAT_BADPOS;
				end
			end
			default: begin
				idx_ld = '0;
			end
		endcase
	end

	always_comb begin
		stat.ok = ok;
		stat.fill = (mode_q == MODE_INSERT);
		case (mode_q)
			MODE_INSERT: stat.more = (idx_q >= pos_q);
			MODE_DELETE: stat.more = (idx_q < count_q);
			MODE_RETRIEVE: stat.more = !got_q;
			default: stat.more = (idx_q < count_q) && !hit_q;
		endcase
	end

	always_comb begin
		case (mode_q)
			MODE_INSERT: ram_raddr = ADDR_W'(idx_q - CNT_W'(1));
			MODE_RETRIEVE: ram_raddr = ADDR_W'(pos_q - CNT_W'(1));
			default: ram_raddr = ADDR_W'(idx_q);
		endcase
		ram_we = 1'b0;
		ram_waddr = ADDR_W'(pos_q - CNT_W'(1));
		ram_wdata = val_q;
		if (cmd.fill) begin
			ram_we = 1'b1;
		end else if (cmd.wr && mode_q == MODE_INSERT) begin
			ram_we = 1'b1;
			ram_waddr = ADDR_W'(idx_q);
			ram_wdata = ram_rdata;
		end else if (cmd.wr && mode_q == MODE_DELETE) begin
			ram_we = 1'b1;
			ram_waddr = ADDR_W'(idx_q - CNT_W'(1));
			ram_wdata = ram_rdata;
		end
	end

	always_comb begin
		count_nx = count_q;
		if (ok && mode_q == MODE_INSERT) begin
			count_nx = count_q + CNT_W'(1);
		end else if (ok && mode_q == MODE_DELETE) begin
			count_nx = count_q - CNT_W'(1);
		end
	end

	pal_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(cmd.rd),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			code_q <= STAT_OK;
			mode_q <= MODE_INSERT;
			idx_q <= '0;
			pos_q <= '0;
			hit_q <= 1'b0;
			got_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				mode_q <= in_data.mode;
				pos_q <= in_data.position;
				code_q <= code_ld;
				idx_q <= idx_ld;
				hit_q <= 1'b0;
				got_q <= 1'b0;
			end else if (cmd.wr) begin
				case (mode_q)
					MODE_INSERT: idx_q <= idx_q - CNT_W'(1);
					MODE_DELETE: idx_q <= idx_q + CNT_W'(1);
					MODE_RETRIEVE: got_q <= 1'b1;
					default: begin
						if (ram_rdata == val_q) begin
							hit_q <= 1'b1;
						end else begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end
				endcase
			end
			if (cmd.emit) begin
				count_q <= count_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= in_data.value;
		end
		if (cmd.wr && mode_q == MODE_RETRIEVE) begin
			rd_q <= ram_rdata;
		end
		if (cmd.emit) begin
			out_q.read_value <= (mode_q == MODE_RETRIEVE && ok) ? rd_q : '0;
			if (mode_q == MODE_LOCATE) begin
				out_q.found_position <= hit_q ? idx_q + CNT_W'(1) : cnt_p1;
			end else begin
				out_q.found_position <= '0;
			end
			out_q.status <= code_q;
			out_q.length <= count_nx;
		end
	end

	assign out_data = out_q;

endmodule

@@ design/positional_array_list.sv @@
// top level of the positional array list
// depends on pal_pkg, pal_ctrl and pal_datapath
//
// usage:
//   in channel (in_valid, in_ready, in_data) takes one request beat:
//   mode, 1-based position and value. out channel (out_valid, out_ready,
//   out_data) returns one result beat per request: read value, found
//   position, status and list length after the request.
//   one request is worked at a time; in_ready is high only when idle.
//   every entry moved or compared goes through an index check, a memory
//   read and a memory write or compare in the single-read, single-write
//   entry memory; with count n and position p, insert moves n-p+1
//   entries, delete moves n-p, retrieve reads one and locate compares
//   entries until the first hit or the end of the list.
//   rejected requests move no entries.
//   the result sits in an output register; if the receiver stalls, the
//   next request may be taken and worked, and waits before its result
//   until the pending beat is taken.
//   reset empties the list at once; no clearing pass of the memory.
module positional_array_list import pal_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output rsp_t out_data
);

	pal_cmd_t cmd;
	pal_stat_t stat;

	pal_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat(stat),
		.cmd(cmd)
	);

	pal_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cmd(cmd),
		.stat(stat),
		.out_data(out_data)
	);

endmodule

@@ design/pal_checker.sv @@
// port-level checks for the positional array list, bound to the top level
// depends on pal_pkg and positional_array_list_assert.svh
`include "positional_array_list_assert.svh"

module pal_checker import pal_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input req_t in_data,
	input logic out_valid,
	input logic out_ready,
	input rsp_t out_data
);

	`PAL_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data), "request beat changed")
	`PAL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat dropped or changed while stalled")
	`PAL_ASSERT_IMPLY(a_len_max, out_valid, out_data.length <= CNT_W'(CAPACITY), "length beyond capacity")
	`PAL_ASSERT_IMPLY(a_rd_ok, out_valid && out_data.status != STAT_OK, out_data.read_value == '0, "read value on a failed request")
	`PAL_ASSERT_IMPLY(a_found_range, out_valid, {1'b0, out_data.found_position} <= {1'b0, out_data.length} + 9'd1, "found position beyond length plus one")

endmodule

bind positional_array_list pal_checker u_pal_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.in_data(in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);

@@ sim/pal_list_checker.sv @@
`timescale 1ns / 100ps
// result checker for the positional array list: keeps its own copy of the list,
// predicts the result of every request beat and compares each result beat with it
// depends on pal_pkg
module pal_list_checker import pal_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input req_t in_data,
	input logic out_valid,
	input logic out_ready,
	input rsp_t out_data,
	output int errors,
	output int pending
);

	logic signed [DATA_W-1:0] list_vals [CAPACITY];
	int list_len;
	rsp_t result_q [$];
	rsp_t due_rsp;

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 30) begin
			$display("%0t ns mismatch: %s", $time, what);
		end
	endtask

	function automatic logic [1:0] classify_position(input int p);
		if (p == 0 || p > list_len + 1) return STAT_BADPOS;
		if (list_len == 0) return STAT_EMPTY;
		if (p > list_len) return STAT_BADPOS;
		return STAT_OK;
	endfunction

	function automatic rsp_t apply_request(input req_t req);
		rsp_t res;
		int p;
		int i;
		logic hit;
		res = '0;
		p = int'(req.position);
		hit = 1'b0;
		case (req.mode)
			MODE_INSERT: begin
				if (list_len >= CAPACITY) begin
					res.status = STAT_FULL;
				end else if (p == 0 || p > list_len + 1) begin
					res.status = STAT_BADPOS;
				end else begin
					for (i = list_len; i >= p; i--) list_vals[i] = list_vals[i - 1];
					list_vals[p - 1] = req.value;
					list_len++;
				end
			end
			MODE_DELETE: begin
				res.status = classify_position(p);
				if (res.status == STAT_OK) begin
					for (i = p; i < list_len; i++) list_vals[i - 1] = list_vals[i];
					list_len--;
				end
			end
			MODE_RETRIEVE: begin
				res.status = classify_position(p);
				if (res.status == STAT_OK) res.read_value = list_vals[p - 1];
			end
			MODE_LOCATE: begin
				res.found_position = CNT_W'(list_len + 1);
				for (i = 0; i < list_len; i++) begin
					if (!hit && list_vals[i] == req.value) begin
						res.found_position = CNT_W'(i + 1);
						hit = 1'b1;
					end
				end
			end
		endcase
		res.length = CNT_W'(list_len);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			result_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					report_mismatch("result beat with no request waiting");
				end else begin
					due_rsp = result_q.pop_front();
					if (out_data.read_value !== due_rsp.read_value)
						report_mismatch($sformatf("read_value %0d, expected %0d",
							out_data.read_value, due_rsp.read_value));
					if (out_data.found_position !== due_rsp.found_position)
						report_mismatch($sformatf("found_position %0d, expected %0d",
							out_data.found_position, due_rsp.found_position));
					if (out_data.status !== due_rsp.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							out_data.status, due_rsp.status));
					if (out_data.length !== due_rsp.length)
						report_mismatch($sformatf("length %0d, expected %0d",
							out_data.length, due_rsp.length));
				end
			end
			if (in_valid && in_ready) result_q.push_back(apply_request(in_data));
		end
		pending = result_q.size();
	end

endmodule

@@ sim/tb_positional_array_list.sv @@
`timescale 1ns / 100ps
// testbench top for the positional array list: drives request beats and result
// stalls, gives the verdict; depends on pal_pkg, positional_array_list, pal_list_checker
module tb_positional_array_list import pal_pkg::*; ();

	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 400;
	localparam int PHASE_ITEMS = 440;

	typedef enum int {TREND_FILL, TREND_MIX, TREND_DRAIN} trend_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in_data;
	logic out_valid;
	logic out_ready;
	rsp_t out_data;

	int gap_pct;
	int stall_pct;
	int list_size;
	int requests_sent;
	int results_seen;
	int cycle_count;
	int peak_length;
	int status_seen [4];
	int check_errors;
	int check_pending;
	logic signed [DATA_W-1:0] value_pool [12];

	positional_array_list DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	pal_list_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.errors(check_errors),
		.pending(check_pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		out_ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			status_seen[out_data.status] <= status_seen[out_data.status] + 1;
			if (out_data.length > peak_length) peak_length <= out_data.length;
		end
	end

	function automatic req_t pack_request(input logic [1:0] mode, input int pos,
			input logic signed [DATA_W-1:0] val);
		req_t req;
		req.mode = mode;
		req.position = CNT_W'(pos);
		req.value = val;
		return req;
	endfunction

	function automatic req_t random_request(input trend_t trend);
		int roll;
		int pos_hi;
		logic [1:0] mode;
		int pos;
		logic signed [DATA_W-1:0] val;
		roll = $urandom_range(99);
		if (trend == TREND_FILL) begin
			mode = roll < 75 ? MODE_INSERT : roll < 80 ? MODE_DELETE :
				roll < 90 ? MODE_RETRIEVE : MODE_LOCATE;
		end else if (trend == TREND_DRAIN) begin
			mode = roll < 12 ? MODE_INSERT : roll < 75 ? MODE_DELETE :
				roll < 90 ? MODE_RETRIEVE : MODE_LOCATE;
		end else begin
			mode = roll < 30 ? MODE_INSERT : roll < 55 ? MODE_DELETE :
				roll < 78 ? MODE_RETRIEVE : MODE_LOCATE;
		end
		pos_hi = (mode == MODE_INSERT) ? list_size + 1 : (list_size > 0 ? list_size : 1);
		if (pos_hi > 129) pos_hi = 129;
		roll = $urandom_range(99);
		if (roll < 85) pos = $urandom_range(pos_hi, 1);
		else if (roll < 89) pos = 0;
		else if (roll < 92) pos = (list_size + 1 > 129) ? 129 : list_size + 1;
		else if (roll < 95) pos = (list_size + 2 > 129) ? 129 : list_size + 2;
		else pos = $urandom_range(129);
		if ($urandom_range(99) < 60) val = value_pool[$urandom_range(11)];
		else val = $urandom;
		return pack_request(mode, pos, val);
	endfunction

	task automatic send_request(input req_t req);
		if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < gap_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		requests_sent++;
		case (req.mode)
			MODE_INSERT: begin
				if (list_size < CAPACITY && req.position != 0 && req.position <= list_size + 1)
					list_size++;
			end
			MODE_DELETE: begin
				if (req.position != 0 && req.position <= list_size) list_size--;
			end
			default: begin
			end
		endcase
	endtask

	task automatic wait_results;
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_seen != requests_sent) @(posedge clk);
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("run stopped after %0d cycles with %0d results missing", cycle_count,
			requests_sent - results_seen);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int phase;
		int k;
		trend_t trend;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		list_size = 0;
		value_pool[0] = 0;
		value_pool[1] = -1;
		value_pool[2] = 32'sh8000_0000;
		value_pool[3] = 32'sh7fff_ffff;
		value_pool[4] = 1;
		for (k = 5; k < 12; k++) value_pool[k] = $urandom;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// empty list corners
		send_request(pack_request(MODE_RETRIEVE, 1, 0));
		send_request(pack_request(MODE_DELETE, 1, 0));
		send_request(pack_request(MODE_RETRIEVE, 0, 0));
		send_request(pack_request(MODE_DELETE, 2, 0));
		send_request(pack_request(MODE_RETRIEVE, 129, 0));
		send_request(pack_request(MODE_LOCATE, 0, 0));
		send_request(pack_request(MODE_INSERT, 0, 5));
		send_request(pack_request(MODE_INSERT, 2, 5));
		// build 0, min, max, -1
		send_request(pack_request(MODE_INSERT, 1, 32'sh8000_0000));
		send_request(pack_request(MODE_INSERT, 2, 32'sh7fff_ffff));
		send_request(pack_request(MODE_INSERT, 1, 0));
		send_request(pack_request(MODE_INSERT, 4, -1));
		send_request(pack_request(MODE_INSERT, 6, 7));
		send_request(pack_request(MODE_RETRIEVE, 4, 0));
		send_request(pack_request(MODE_RETRIEVE, 5, 0));
		send_request(pack_request(MODE_RETRIEVE, 1, 0));
		send_request(pack_request(MODE_LOCATE, 128, 32'sh7fff_ffff));
		send_request(pack_request(MODE_LOCATE, 3, 12345));
		// duplicate value, locate returns the first one
		send_request(pack_request(MODE_INSERT, 3, -1));
		send_request(pack_request(MODE_LOCATE, 255, -1));
		send_request(pack_request(MODE_DELETE, 6, 0));
		send_request(pack_request(MODE_DELETE, 5, 0));
		send_request(pack_request(MODE_DELETE, 1, 0));
		send_request(pack_request(MODE_DELETE, 128, 0));

		for (phase = 0; phase < 4; phase++) begin
			wait_results();
			case (phase)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 84;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 84;
				end
				default: begin
					gap_pct = 14;
					stall_pct = 14;
				end
			endcase
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (k < 160) trend = TREND_FILL;
				else if (k < 280) trend = TREND_MIX;
				else trend = TREND_DRAIN;
				send_request(random_request(trend));
			end
		end

		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d requests under four stall mixes: %0d ok, %0d full, %0d bad position,",
			requests_sent, status_seen[STAT_OK], status_seen[STAT_FULL],
			status_seen[STAT_BADPOS]);
		$display("%0d empty; longest list %0d of %0d entries, %0d mismatches",
			status_seen[STAT_EMPTY], peak_length, CAPACITY, check_errors);
		if (check_errors == 0 && check_pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
